FILE: src/cse_pkg.sv
`default_nettype none
package cse_pkg;

   localparam int COMMAND_W  = 3;
   localparam int RANK_W     = 32;
   localparam int LIMIT_W    = 7;
   localparam int LOAD_POS_W = 3;
   localparam int LOAD_VAL_W = 6;
   localparam int POSITION_W = 3;
   localparam int ELEMENT_W  = 7;
   localparam int SIZE_W     = 3;
   localparam int PC_W       = 5;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd2;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_BEGIN  = 3'd0,
      CMD_NEXT   = 3'd1,
      CMD_PREV   = 3'd2,
      CMD_UNRANK = 3'd3,
      CMD_LOAD   = 3'd4
   } command_type;

   typedef enum logic [4:0] {
      UOP_NOP,
      UOP_BEGIN,
      UOP_NEXT_INIT,
      UOP_NEXT_STEP,
      UOP_NEXT_BUMP,
      UOP_IDX_CLR,
      UOP_IDX_INC,
      UOP_IDX_DEC,
      UOP_IDX_TOP,
      UOP_SET_START,
      UOP_PREV_FILL,
      UOP_SRCH_INIT,
      UOP_SRCH_MID,
      UOP_SRCH_CMP,
      UOP_RANK_INIT,
      UOP_RANK_RD,
      UOP_RANK_ADD,
      UOP_EMIT,
      UOP_LOAD
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_TOP_AT_END,
      COND_IDX_EQ_TOP,
      COND_IDX_NE_TOP,
      COND_IDX_NE_ZERO,
      COND_ENTRY_LT_NEXT,
      COND_ELEM_GT_IDX,
      COND_SRCH_MORE
   } cond_type;

   typedef struct packed {
      uop_type           op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } uword_type;

   localparam logic [PC_W-1:0] UA_BEGIN     = 5'd0;
   localparam logic [PC_W-1:0] UA_NEXT      = 5'd1;
   localparam logic [PC_W-1:0] UA_NEXT_TEST = 5'd2;
   localparam logic [PC_W-1:0] UA_NEXT_STEP = 5'd3;
   localparam logic [PC_W-1:0] UA_NEXT_LOOP = 5'd4;
   localparam logic [PC_W-1:0] UA_NEXT_BUMP = 5'd5;
   localparam logic [PC_W-1:0] UA_PREV      = 5'd6;
   localparam logic [PC_W-1:0] UA_PREV_TEST = 5'd7;
   localparam logic [PC_W-1:0] UA_PREV_INC  = 5'd8;
   localparam logic [PC_W-1:0] UA_PREV_NONE = 5'd9;
   localparam logic [PC_W-1:0] UA_PREV_FILL = 5'd10;
   localparam logic [PC_W-1:0] UA_UNRANK    = 5'd11;
   localparam logic [PC_W-1:0] UA_SRCH_INIT = 5'd12;
   localparam logic [PC_W-1:0] UA_SRCH_MID  = 5'd13;
   localparam logic [PC_W-1:0] UA_SRCH_CMP  = 5'd14;
   localparam logic [PC_W-1:0] UA_SRCH_NEXT = 5'd15;
   localparam logic [PC_W-1:0] UA_RANK      = 5'd16;
   localparam logic [PC_W-1:0] UA_RANK_RD   = 5'd17;
   localparam logic [PC_W-1:0] UA_RANK_ADD  = 5'd18;
   localparam logic [PC_W-1:0] UA_EMIT_INIT = 5'd19;
   localparam logic [PC_W-1:0] UA_EMIT      = 5'd20;
   localparam logic [PC_W-1:0] UA_IDLE      = 5'd21;
   localparam logic [PC_W-1:0] UA_LOAD      = 5'd22;

   // control store: op, jump condition, jump target; fall through otherwise
   function automatic uword_type ucode(input logic [PC_W-1:0] addr);
      case (addr)
         UA_BEGIN:     return '{UOP_BEGIN,     COND_ALWAYS,        UA_RANK};
         UA_NEXT:      return '{UOP_NEXT_INIT, COND_TOP_AT_END,    UA_RANK};
         UA_NEXT_TEST: return '{UOP_NOP,       COND_IDX_EQ_TOP,    UA_NEXT_BUMP};
         UA_NEXT_STEP: return '{UOP_NEXT_STEP, COND_ENTRY_LT_NEXT, UA_RANK};
         UA_NEXT_LOOP: return '{UOP_NOP,       COND_ALWAYS,        UA_NEXT_TEST};
         UA_NEXT_BUMP: return '{UOP_NEXT_BUMP, COND_ALWAYS,        UA_RANK};
         UA_PREV:      return '{UOP_IDX_CLR,   COND_NEVER,         UA_IDLE};
         UA_PREV_TEST: return '{UOP_NOP,       COND_ELEM_GT_IDX,   UA_PREV_FILL};
         UA_PREV_INC:  return '{UOP_IDX_INC,   COND_IDX_NE_TOP,    UA_PREV_TEST};
         UA_PREV_NONE: return '{UOP_SET_START, COND_ALWAYS,        UA_RANK};
         UA_PREV_FILL: return '{UOP_PREV_FILL, COND_ALWAYS,        UA_RANK};
         UA_UNRANK:    return '{UOP_IDX_TOP,   COND_NEVER,         UA_IDLE};
         UA_SRCH_INIT: return '{UOP_SRCH_INIT, COND_NEVER,         UA_IDLE};
         UA_SRCH_MID:  return '{UOP_SRCH_MID,  COND_NEVER,         UA_IDLE};
         UA_SRCH_CMP:  return '{UOP_SRCH_CMP,  COND_SRCH_MORE,     UA_SRCH_MID};
         UA_SRCH_NEXT: return '{UOP_IDX_DEC,   COND_IDX_NE_ZERO,   UA_SRCH_INIT};
         UA_RANK:      return '{UOP_RANK_INIT, COND_NEVER,         UA_IDLE};
         UA_RANK_RD:   return '{UOP_RANK_RD,   COND_NEVER,         UA_IDLE};
         UA_RANK_ADD:  return '{UOP_RANK_ADD,  COND_IDX_NE_TOP,    UA_RANK_RD};
         UA_EMIT_INIT: return '{UOP_IDX_CLR,   COND_NEVER,         UA_IDLE};
         UA_EMIT:      return '{UOP_EMIT,      COND_IDX_NE_TOP,    UA_EMIT};
         UA_IDLE:      return '{UOP_NOP,       COND_ALWAYS,        UA_IDLE};
         UA_LOAD:      return '{UOP_LOAD,      COND_ALWAYS,        UA_IDLE};
         default:      return '{UOP_NOP,       COND_ALWAYS,        UA_IDLE};
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: src/cse_if.sv
`default_nettype none
interface cse_req_if import cse_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [COMMAND_W-1:0]  command;
   logic [RANK_W-1:0]     rank_in;
   logic [LIMIT_W-1:0]    upper_limit;
   logic [LOAD_POS_W-1:0] load_position;
   logic [LOAD_VAL_W-1:0] load_value;

   modport source (
      output valid, command, rank_in, upper_limit, load_position, load_value,
      input  ready
   );
   modport sink (
      input  valid, command, rank_in, upper_limit, load_position, load_value,
      output ready
   );
endinterface

interface cse_rsp_if import cse_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [POSITION_W-1:0] position;
   logic [ELEMENT_W-1:0]  element;
   logic                  last;
   logic [RANK_W-1:0]     rank_out;
   logic                  past_end;
   logic                  at_start;

   modport source (
      output valid, position, element, last, rank_out, past_end, at_start,
      input  ready
   );
   modport sink (
      input  valid, position, element, last, rank_out, past_end, at_start,
      output ready
   );
endinterface

interface cse_csr_if import cse_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] data;

   modport source (
      output valid, data,
      input  ready
   );
   modport sink (
      input  valid, data,
      output ready
   );
endinterface
`default_nettype wire

FILE: src/combinadic_subset_engine.sv
// Microcoded colex subset engine; one command in flight at a time.
// Begin/next/previous: t results out, then ready again.
// Unrank: adds a binary search per position (at most 7 probes at 64), each compare
//   fed by the registered binomial ROM read.
// Load: no result. Configuration writes are always ready.
// Synchronous reset: subset = 0..MAX_SUBSET-1, size = 2, sequencer idle.
`default_nettype none
module combinadic_subset_engine
   import cse_pkg::*;
#(
   parameter int MAX_SUBSET = 6,
   parameter int UNIVERSE   = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   cse_req_if.sink   req_bus,
   cse_rsp_if.source rsp_bus,
   cse_csr_if.sink   csr_bus
);

   localparam int VMAX  = (UNIVERSE > MAX_SUBSET) ? UNIVERSE : MAX_SUBSET;
   localparam int EW    = $clog2(VMAX + 1);
   localparam int IW    = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
   localparam int TW    = $clog2(MAX_SUBSET + 1);
   localparam int NW    = $clog2(UNIVERSE + 1);
   localparam int ROM_W = RANK_W + 1;

   // binomial ROM entry: low 32 bits exact, top bit flags value >= 2^32
   function automatic logic [ROM_W-1:0] binom_entry(input int n, input int r);
      logic [63:0] row [MAX_SUBSET+1];
      for (int b = 0; b <= MAX_SUBSET; b++) row[b] = (b == 0) ? 64'd1 : 64'd0;
      for (int a = 0; a < n; a++) begin
         for (int b = MAX_SUBSET; b > 0; b--) row[b] = row[b] + row[b - 1];
      end
      return {|row[r][63:32], row[r][31:0]};
   endfunction

   logic [ROM_W-1:0] binom_rom [UNIVERSE+1][MAX_SUBSET+1];

   for (genvar gn = 0; gn <= UNIVERSE; gn++) begin : g_rom_n
      for (genvar gr = 0; gr <= MAX_SUBSET; gr++) begin : g_rom_r
         assign binom_rom[gn][gr] = binom_entry(gn, gr);
      end
   end

   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [EW-1:0]         elem_ff [MAX_SUBSET];
   logic [EW-1:0]         elem_in [MAX_SUBSET];
   logic [IW-1:0]         idx_ff, idx_in;
   logic [EW-1:0]         acc_ff, acc_in;
   logic [EW-1:0]         lo_ff, lo_in;
   logic [EW-1:0]         hi_ff, hi_in;
   logic [EW-1:0]         mid_ff, mid_in;
   logic [EW-1:0]         hilim_ff, hilim_in;
   logic [RANK_W-1:0]     rem_ff, rem_in;
   logic [RANK_W-1:0]     lo_val_ff, lo_val_in;
   logic [RANK_W-1:0]     rank_acc_ff, rank_acc_in;
   logic                  past_ff, past_in;
   logic                  start_ff, start_in;
   logic [LOAD_POS_W-1:0] ld_pos_ff, ld_pos_in;
   logic [EW-1:0]         ld_val_ff, ld_val_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [ROM_W-1:0]      rom_q_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POSITION_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [ELEMENT_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [RANK_W-1:0]     rsp_rank_ff, rsp_rank_in;
   logic                  rsp_past_ff, rsp_past_in;
   logic                  rsp_start_ff, rsp_start_in;

   uword_type             uw;
   logic [TW-1:0]         size_eff;
   logic [IW-1:0]         top;
   logic [IW-1:0]         idx_nxt;
   logic [EW-1:0]         elem_cur, elem_up, elem_top;
   logic                  top_at_end;
   logic [EW:0]           entry;
   logic                  entry_lt;
   logic                  elem_gt_idx;
   logic [EW:0]           mid_sum;
   logic [EW-1:0]         mid_new;
   logic [EW-1:0]         srch_lo, srch_hi;
   logic                  q_big;
   logic [RANK_W-1:0]     q_low;
   logic                  less;
   logic                  srch_done;
   logic                  slot_free, stall, cond_true, accept;
   logic [EW-1:0]         rom_sel;
   logic [NW-1:0]         rom_n;
   logic [TW-1:0]         rom_r;
   logic [PC_W-1:0]       entry_pc;

   always_comb begin
      if (size_ff == '0) begin
         size_eff = TW'(1);
      end else if (int'(size_ff) > MAX_SUBSET) begin
         size_eff = TW'(MAX_SUBSET);
      end else begin
         size_eff = TW'(size_ff);
      end
      top = IW'(size_eff - TW'(1));
   end

   assign uw          = ucode(pc_ff);
   assign idx_nxt     = IW'(idx_ff + IW'(1));
   assign elem_cur    = elem_ff[idx_ff];
   assign elem_top    = elem_ff[top];
   assign elem_up     = (idx_ff != top) ? elem_ff[idx_nxt] : '0;
   assign top_at_end  = int'(elem_top) >= UNIVERSE;
   assign entry       = {1'b0, acc_ff} + (EW+1)'(1);
   assign entry_lt    = entry < {1'b0, elem_up};
   assign elem_gt_idx = elem_cur > EW'(idx_ff);
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_new     = mid_sum[EW:1];
   assign q_big       = rom_q_ff[RANK_W];
   assign q_low       = rom_q_ff[RANK_W-1:0];
   assign less        = q_big || (rem_ff < q_low);
   assign srch_done   = less ? ((mid_ff - lo_ff) <= EW'(1)) : ((hi_ff - mid_ff) <= EW'(1));

   always_comb begin
      srch_lo = EW'(idx_ff);
      srch_hi = (idx_ff == top) ? hilim_ff : elem_up;
      if (srch_hi <= srch_lo) begin
         srch_hi = srch_lo + EW'(1);
      end
   end

   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;
   assign stall         = (uw.op == UOP_EMIT) && !slot_free;
   assign req_bus.ready = (pc_ff == UA_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      case (uw.cond)
         COND_NEVER:         cond_true = 1'b0;
         COND_ALWAYS:        cond_true = 1'b1;
         COND_TOP_AT_END:    cond_true = top_at_end;
         COND_IDX_EQ_TOP:    cond_true = (idx_ff == top);
         COND_IDX_NE_TOP:    cond_true = (idx_ff != top);
         COND_IDX_NE_ZERO:   cond_true = (idx_ff != '0);
         COND_ENTRY_LT_NEXT: cond_true = entry_lt;
         COND_ELEM_GT_IDX:   cond_true = elem_gt_idx;
         COND_SRCH_MORE:     cond_true = !srch_done;
         default:            cond_true = 1'b0;
      endcase
   end

   always_comb begin
      case (req_bus.command)
         CMD_BEGIN:  entry_pc = UA_BEGIN;
         CMD_NEXT:   entry_pc = UA_NEXT;
         CMD_PREV:   entry_pc = UA_PREV;
         CMD_UNRANK: entry_pc = UA_UNRANK;
         CMD_LOAD:   entry_pc = UA_LOAD;
         default:    entry_pc = UA_IDLE;
      endcase
   end

   // ROM address: search midpoint or current element, clamped to the universe
   always_comb begin
      rom_sel = (uw.op == UOP_SRCH_MID) ? mid_new : elem_cur;
      rom_n   = (int'(rom_sel) > UNIVERSE) ? NW'(UNIVERSE) : NW'(rom_sel);
      rom_r   = TW'(idx_ff) + TW'(1);
   end

   always_comb begin
      pc_in        = pc_ff;
      elem_in      = elem_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      hilim_in     = hilim_ff;
      rem_in       = rem_ff;
      lo_val_in    = lo_val_ff;
      rank_acc_in  = rank_acc_ff;
      past_in      = past_ff;
      start_in     = start_ff;
      ld_pos_in    = ld_pos_ff;
      ld_val_in    = ld_val_ff;
      size_in      = size_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_past_in  = rsp_past_ff;
      rsp_start_in = rsp_start_ff;

      if (csr_bus.valid) begin
         size_in = csr_bus.data;
      end

      if (accept) begin
         pc_in     = entry_pc;
         rem_in    = req_bus.rank_in;
         hilim_in  = (int'(req_bus.upper_limit) > UNIVERSE) ? EW'(UNIVERSE)
                                                             : EW'(req_bus.upper_limit);
         ld_pos_in = req_bus.load_position;
         ld_val_in = (int'(req_bus.load_value) > UNIVERSE - 1) ? EW'(UNIVERSE - 1)
                                                                : EW'(req_bus.load_value);
         past_in   = 1'b0;
         start_in  = 1'b0;
      end else if (!stall) begin
         pc_in = cond_true ? uw.target : PC_W'(pc_ff + PC_W'(1));
         case (uw.op)
            UOP_NOP: begin
            end
            UOP_BEGIN: begin
               for (int j = 0; j < MAX_SUBSET; j++) begin
                  if (j < int'(size_eff)) elem_in[j] = EW'(j);
               end
            end
            UOP_NEXT_INIT: begin
               past_in = top_at_end;
               acc_in  = elem_ff[0];
               idx_in  = '0;
            end
            UOP_NEXT_STEP: begin
               if (entry_lt) begin
                  elem_in[idx_ff] = entry[EW-1:0];
               end else begin
                  elem_in[idx_ff] = EW'(idx_ff);
                  acc_in          = elem_up;
                  idx_in          = idx_nxt;
               end
            end
            UOP_NEXT_BUMP: begin
               elem_in[top] = elem_top + EW'(1);
               past_in      = (int'(elem_top) + 1) >= UNIVERSE;
            end
            UOP_IDX_CLR: idx_in = '0;
            UOP_IDX_INC: idx_in = idx_nxt;
            UOP_IDX_DEC: idx_in = IW'(idx_ff - IW'(1));
            UOP_IDX_TOP: idx_in = top;
            UOP_SET_START: start_in = 1'b1;
            UOP_PREV_FILL: begin
               for (int j = 0; j < MAX_SUBSET; j++) begin
                  if (j <= int'(idx_ff)) begin
                     elem_in[j] = EW'(int'(elem_cur) - int'(idx_ff) - 1 + j);
                  end
               end
            end
            UOP_SRCH_INIT: begin
               lo_in     = srch_lo;
               hi_in     = srch_hi;
               lo_val_in = '0;
            end
            UOP_SRCH_MID: mid_in = mid_new;
            UOP_SRCH_CMP: begin
               if (less) begin
                  if (srch_done) begin
                     rem_in          = rem_ff - lo_val_ff;
                     elem_in[idx_ff] = lo_ff;
                  end else begin
                     hi_in = mid_ff;
                  end
               end else begin
                  if (srch_done) begin
                     rem_in          = rem_ff - q_low;
                     elem_in[idx_ff] = mid_ff;
                  end else begin
                     lo_in     = mid_ff;
                     lo_val_in = q_low;
                  end
               end
            end
            UOP_RANK_INIT: begin
               rank_acc_in = '0;
               idx_in      = '0;
            end
            UOP_RANK_RD: begin
            end
            UOP_RANK_ADD: begin
               rank_acc_in = rank_acc_ff + q_low;
               idx_in      = idx_nxt;
            end
            UOP_EMIT: begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POSITION_W'(idx_ff);
               rsp_elem_in  = ELEMENT_W'(elem_cur);
               rsp_last_in  = (idx_ff == top);
               rsp_rank_in  = rank_acc_ff;
               rsp_past_in  = past_ff;
               rsp_start_in = start_ff;
               idx_in       = idx_nxt;
            end
            UOP_LOAD: begin
               if (int'(ld_pos_ff) < int'(size_eff)) elem_in[IW'(ld_pos_ff)] = ld_val_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= UA_IDLE;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_SUBSET; j++) elem_ff[j] <= EW'(j);
      end else begin
         pc_ff        <= pc_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         elem_ff      <= elem_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      hilim_ff     <= hilim_in;
      rem_ff       <= rem_in;
      lo_val_ff    <= lo_val_in;
      rank_acc_ff  <= rank_acc_in;
      past_ff      <= past_in;
      start_ff     <= start_in;
      ld_pos_ff    <= ld_pos_in;
      ld_val_ff    <= ld_val_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_past_ff  <= rsp_past_in;
      rsp_start_ff <= rsp_start_in;
      rom_q_ff     <= binom_rom[rom_n][rom_r];
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.position = rsp_pos_ff;
   assign rsp_bus.element  = rsp_elem_ff;
   assign rsp_bus.last     = rsp_last_ff;
   assign rsp_bus.rank_out = rsp_rank_ff;
   assign rsp_bus.past_end = rsp_past_ff;
   assign rsp_bus.at_start = rsp_start_ff;

   a_last_at_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_pos_ff == POSITION_W'(top))))
      else $error("last flag not on top position");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_past_ff && rsp_start_ff))
      else $error("past_end and at_start both set");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= UA_LOAD)
      else $error("sequencer outside control store");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_bus.command == CMD_BEGIN || req_bus.command == CMD_NEXT ||
                  req_bus.command == CMD_PREV || req_bus.command == CMD_UNRANK ||
                  req_bus.command == CMD_LOAD)) |=> !req_bus.ready)
      else $error("ready after command transfer");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import cse_pkg::*;

   localparam int MAX_SUBSET   = 6;
   localparam int UNIVERSE     = 64;
   localparam int GAP_MAX      = 11;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS  = 32;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [COMMAND_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [COMMAND_W-1:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic [COMMAND_W-1:0]  command;
      logic [RANK_W-1:0]     rank_in;
      logic [LIMIT_W-1:0]    upper_limit;
      logic [LOAD_POS_W-1:0] load_position;
      logic [LOAD_VAL_W-1:0] load_value;
   } request_t;

   typedef struct packed {
      logic [POSITION_W-1:0] position;
      logic [ELEMENT_W-1:0]  element;
      logic                  last;
      logic [RANK_W-1:0]     rank_out;
      logic                  past_end;
      logic                  at_start;
   } report_t;

   class subset_tracker;
      bit [SIZE_W-1:0]    size_reg;
      bit [ELEMENT_W-1:0] elems [MAX_SUBSET];
      report_t            pending_reports [$];
      int                 mismatches;

      function new();
         size_reg = SIZE_RESET;
         foreach (elems[i]) elems[i] = i;
         mismatches = 0;
      endfunction

      function void set_size(bit [SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      function int active_size();
         if (size_reg == 0) return 1;
         if (size_reg > MAX_SUBSET) return MAX_SUBSET;
         return size_reg;
      endfunction

      function longint unsigned choose(int unsigned n, int unsigned r);
         longint unsigned c;
         c = 1;
         if (n > UNIVERSE) n = UNIVERSE;
         if (r > n) return 0;
         for (int unsigned j = 0; j < r; j++) c = c * (n - j) / (j + 1);
         return c;
      endfunction

      // largest v in [lo, hi) with C(v, r) <= k; k is reduced by C(v, r)
      function int unsigned bisect(int unsigned lo, int unsigned hi, int unsigned r,
                                   inout bit [31:0] k);
         int unsigned     mid;
         int unsigned     pick;
         longint unsigned cur;
         bit              done;
         done = 0;
         pick = lo;
         if (hi <= lo) hi = lo + 1;
         while (!done) begin
            mid = (lo + hi) / 2;
            cur = choose(mid, r);
            if (k < cur) begin
               if (mid - lo <= 1) begin
                  k = k - choose(lo, r);
                  pick = lo;
                  done = 1;
               end else begin
                  hi = mid;
               end
            end else begin
               if (hi - mid <= 1) begin
                  k = k - cur;
                  pick = mid;
                  done = 1;
               end else begin
                  lo = mid;
               end
            end
         end
         return pick;
      endfunction

      function void note_request(request_t rq);
         int          t;
         int          top;
         bit          past;
         bit          start;
         bit          found;
         int unsigned ceiling;
         int unsigned entry;
         int unsigned hi;
         bit [31:0]   k;
         bit [31:0]   rank;
         report_t     rpt;
         t = active_size();
         top = t - 1;
         past = 0;
         start = 0;
         found = 0;
         case (rq.command)
            CMD_BEGIN: begin
               for (int i = 0; i < t; i++) elems[i] = i;
            end
            CMD_NEXT: begin
               if (elems[top] >= UNIVERSE) begin
                  past = 1;
               end else begin
                  ceiling = elems[0];
                  for (int i = 0; i < top && !found; i++) begin
                     entry = ceiling + 1;
                     ceiling = elems[i + 1];
                     if (entry < ceiling) begin
                        elems[i] = entry;
                        found = 1;
                     end else begin
                        elems[i] = i;
                     end
                  end
                  if (!found) begin
                     elems[top] = elems[top] + 1;
                     if (elems[top] >= UNIVERSE) past = 1;
                  end
               end
            end
            CMD_PREV: begin
               for (int i = 0; i < t && !found; i++) begin
                  if (elems[i] > i) begin
                     entry = elems[i];
                     for (int j = i; j >= 0; j--) begin
                        entry--;
                        elems[j] = entry;
                     end
                     found = 1;
                  end
               end
               if (!found) start = 1;
            end
            CMD_UNRANK: begin
               k = rq.rank_in;
               hi = rq.upper_limit;
               if (hi > UNIVERSE) hi = UNIVERSE;
               elems[top] = bisect(top, hi, t, k);
               for (int i = top - 1; i >= 0; i--) elems[i] = bisect(i, elems[i + 1], i + 1, k);
            end
            CMD_LOAD: begin
               if (rq.load_position < t) elems[rq.load_position] = rq.load_value;
               return;
            end
            default: return;
         endcase
         rank = 0;
         for (int i = 0; i < t; i++) rank = rank + choose(elems[i], i + 1);
         for (int i = 0; i < t; i++) begin
            rpt.position = i;
            rpt.element  = elems[i];
            rpt.last     = (i == top);
            rpt.rank_out = rank;
            rpt.past_end = past;
            rpt.at_start = start;
            pending_reports.push_back(rpt);
         end
      endfunction

      function string describe(report_t r);
         return $sformatf("pos %0d elem %0d last %0b rank %0d past_end %0b at_start %0b",
                          r.position, r.element, r.last, r.rank_out, r.past_end, r.at_start);
      endfunction

      function void note_failure(string msg);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      function void check_result(report_t got);
         report_t want;
         if (pending_reports.size() == 0) begin
            note_failure($sformatf("unexpected result: %s", describe(got)));
            return;
         end
         want = pending_reports.pop_front();
         if (got.position !== want.position || got.element !== want.element ||
             got.last !== want.last || got.rank_out !== want.rank_out ||
             got.past_end !== want.past_end || got.at_start !== want.at_start)
            note_failure($sformatf("mismatch: expected %s / actual %s",
                                   describe(want), describe(got)));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   bit   steady = 0;

   bit [SIZE_W-1:0] size_plan [8] = '{3'd7, 3'd0, 3'd1, 3'd6, 3'd3, 3'd5, 3'd4, 3'd2};

   subset_tracker tracker;

   cse_req_if req_bus ();
   cse_rsp_if rsp_bus ();
   cse_csr_if csr_bus ();

   combinadic_subset_engine #(
      .MAX_SUBSET (MAX_SUBSET),
      .UNIVERSE   (UNIVERSE)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic request_t build(logic [COMMAND_W-1:0] cmd, logic [RANK_W-1:0] rank,
                                      logic [LIMIT_W-1:0] limit, logic [LOAD_POS_W-1:0] pos,
                                      logic [LOAD_VAL_W-1:0] val);
      request_t rq;
      rq.command       = cmd;
      rq.rank_in       = rank;
      rq.upper_limit   = limit;
      rq.load_position = pos;
      rq.load_value    = val;
      return rq;
   endfunction

   function automatic request_t random_request();
      request_t        rq;
      int              t;
      int              roll;
      longint unsigned span;
      t = tracker.active_size();
      rq = build(CMD_NEXT, $urandom(), $urandom_range(0, 127), $urandom_range(0, 7),
                 $urandom_range(0, 63));
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         rq.command = CMD_NEXT;
      end else if (roll < 50) begin
         rq.command = CMD_PREV;
      end else if (roll < 75) begin
         rq.command = CMD_UNRANK;
         if (roll < 68) begin
            rq.upper_limit = $urandom_range(0, 1) ? UNIVERSE : $urandom_range(t, UNIVERSE);
            span = tracker.choose(rq.upper_limit, t);
            if (span > 0) rq.rank_in = $urandom_range(0, span - 1);
         end
      end else if (roll < 82) begin
         rq.command = CMD_BEGIN;
      end else if (roll < 95) begin
         rq.command = CMD_LOAD;
         if ($urandom_range(0, 3) != 0) rq.load_position = $urandom_range(0, t - 1);
      end else begin
         rq.command = $urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST);
      end
      return rq;
   endfunction

   task automatic send(request_t rq);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.command       <= rq.command;
      req_bus.rank_in       <= rq.rank_in;
      req_bus.upper_limit   <= rq.upper_limit;
      req_bus.load_position <= rq.load_position;
      req_bus.load_value    <= rq.load_value;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(rq);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(bit [SIZE_W-1:0] value);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      tracker.set_size(value);
   endtask

   task automatic run_random(int budget);
      int              sent;
      int              len;
      request_t        rq;
      longint unsigned span;
      sent = 0;
      while (sent < budget) begin
         steady = ($urandom_range(0, 4) == 0);
         len = $urandom_range(1, 6);
         case ($urandom_range(0, 4))
            0: begin
               // run off the last subset, sometimes step back again
               span = tracker.choose(UNIVERSE, tracker.active_size());
               rq = random_request();
               rq.command = CMD_UNRANK;
               rq.upper_limit = UNIVERSE;
               rq.rank_in = span - 1 - $urandom_range(0, 3);
               send(rq);
               repeat (len) begin
                  rq = random_request();
                  rq.command = CMD_NEXT;
                  send(rq);
               end
               if ($urandom_range(0, 1)) begin
                  rq.command = CMD_PREV;
                  send(rq);
               end
            end
            1: begin
               rq = random_request();
               rq.command = CMD_UNRANK;
               rq.upper_limit = UNIVERSE;
               rq.rank_in = $urandom_range(0, 3);
               send(rq);
               repeat (len) begin
                  rq = random_request();
                  rq.command = CMD_PREV;
                  send(rq);
               end
            end
            default: begin
               repeat (len) send(random_request());
            end
         endcase
         sent += len + 1;
      end
   endtask

   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            report_t got;
            got.position = rsp_bus.position;
            got.element  = rsp_bus.element;
            got.last     = rsp_bus.last;
            got.rank_out = rsp_bus.rank_out;
            got.past_end = rsp_bus.past_end;
            got.at_start = rsp_bus.at_start;
            tracker.check_result(got);
            hold = draw_gap();
            rsp_bus.ready <= (hold == 0);
         end else if (hold > 0) begin
            hold--;
            rsp_bus.ready <= (hold == 0);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      tracker = new();
      req_bus.valid         <= 1'b0;
      req_bus.command       <= CMD_BEGIN;
      req_bus.rank_in       <= '0;
      req_bus.upper_limit   <= '0;
      req_bus.load_position <= '0;
      req_bus.load_value    <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.data          <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset size of two
      send(build(CMD_NEXT, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_PREV, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_PREV, 32'hFFFF_FFFF, 7'd127, 3'd7, 6'd63));
      send(build(CMD_UNRANK, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_UNRANK, 32'd2015, 7'd64, 3'd0, 6'd0));
      send(build(CMD_NEXT, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_NEXT, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_PREV, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_UNRANK, 32'hFFFF_FFFF, 7'd127, 3'd0, 6'd0));
      send(build(CMD_UNRANK, 32'd5, 7'd0, 3'd0, 6'd0));
      send(build(CMD_UNRANK, 32'h8000_0000, 7'd65, 3'd0, 6'd0));
      send(build(CMD_LOAD, 32'd0, 7'd0, 3'd0, 6'd63));
      send(build(CMD_LOAD, 32'd0, 7'd0, 3'd7, 6'd0));
      send(build(CMD_NEXT, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_PREV, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_LOAD, 32'd0, 7'd0, 3'd1, 6'd0));
      send(build(CMD_NEXT, 32'd0, 7'd64, 3'd0, 6'd0));
      send(build(CMD_LOAD, 32'd0, 7'd0, 3'd2, 6'd42));
      send(build(CMD_SPARE_FIRST, 32'hFFFF_FFFF, 7'd127, 3'd7, 6'd63));
      send(build(3'd6, 32'd0, 7'd0, 3'd0, 6'd0));
      send(build(CMD_SPARE_LAST, 32'd0, 7'd0, 3'd0, 6'd0));
      send(build(CMD_BEGIN, 32'hFFFF_FFFF, 7'd127, 3'd7, 6'd63));

      foreach (size_plan[p]) begin
         write_size(size_plan[p]);
         run_random(PHASE_ITEMS);
      end

      wait_idle();
      if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/cse_pkg.sv
src/cse_if.sv
src/combinadic_subset_engine.sv
verif/tb.sv
